@@ src/tspft_pkg.sv @@
// ----------------------------------------------------------------------------
// tspft_pkg
// Shared constants and codes for the transport stream PID selection table.
// ----------------------------------------------------------------------------
package tspft_pkg;

  localparam int PID_W             = 14;
  localparam int PID_SPACE         = 8192;
  localparam int PID_LO_W          = 13;
  localparam int WORD_W            = 32;
  localparam int BIT_SEL_W         = 5;
  localparam int BM_WORDS          = PID_SPACE / WORD_W;
  localparam int BM_AW             = $clog2(BM_WORDS);
  localparam int SMALL_ENTRIES_DEF = 24;

  // feed-through PID
  localparam logic [PID_W-1:0] BYPASS_PID = 14'h2000;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_SET   = 1'b1;

  localparam logic KIND_FULL  = 1'b0;
  localparam logic KIND_SMALL = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

@@ src/tspft_ram.sv @@
// ----------------------------------------------------------------------------
// tspft_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tspft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/ts_pid_filter_table.sv @@
// ----------------------------------------------------------------------------
// ts_pid_filter_table
// PID selection table of a transport stream filter: full 8192-bit bitmap or
// a short slot list, updated by one set/clear request per word.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  input    | start / busy (start&!busy) | in_operation, in_pid
//  result   | out_valid (1-cycle strobe) | out_status, out_bypass_on
//  config   | cfg_valid / cfg_ready      | cfg_filter_kind
//
//  Full mode: bitmap RAM read, then modify and write back (busy is high for
//  one cycle). Small set: first free slot from the valid flops. Small clear:
//  one slot RAM read per cycle until the first match or the last slot.
//  Reset clears valid flops for every bitmap word and slot, so no clearing
//  pass is needed. Results are strobed for one cycle and the receiver cannot
//  stall; a new word may be accepted while the previous result is shown.
// ----------------------------------------------------------------------------
module ts_pid_filter_table #(
  parameter int SMALL_ENTRIES = tspft_pkg::SMALL_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [tspft_pkg::PID_W-1:0] in_pid,
  // result
  output logic                       out_valid,
  output logic                       out_status,
  output logic                       out_bypass_on,
  // config
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_filter_kind
);

  import tspft_pkg::*;

  localparam int SLOT_AW = (SMALL_ENTRIES > 1) ? $clog2(SMALL_ENTRIES) : 1;
  localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(SMALL_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BM_WR,
    S_SM_SET,
    S_SM_SCAN
  } state_t;

  // control / status registers
  state_t                   state_r, state_nxt;
  logic                     kind_r, kind_nxt;
  logic                     bypass_r, bypass_nxt;
  logic [BM_WORDS-1:0]      bm_vld_r, bm_vld_nxt;
  logic [SMALL_ENTRIES-1:0] sl_vld_r, sl_vld_nxt;
  logic [SLOT_AW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [SLOT_AW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // payload registers
  logic                     op_r, op_nxt;
  logic [PID_W-1:0]         pid_r, pid_nxt;
  logic                     out_status_r, out_status_nxt;
  logic                     out_bypass_r, out_bypass_nxt;

  // bitmap RAM
  logic                     bm_we, bm_re;
  logic [BM_AW-1:0]         bm_raddr, bm_waddr;
  logic [WORD_W-1:0]        bm_wdata, bm_rdata, bm_old, bm_mask;

  // slot RAM (13-bit PIDs, validity lives in sl_vld_r)
  logic                     sl_we, sl_re;
  logic [SLOT_AW-1:0]       sl_raddr;
  logic [PID_LO_W-1:0]      sl_rdata;

  // first free slot
  logic                     free_found;
  logic [SLOT_AW-1:0]       free_idx;

  tspft_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BM_WORDS)
  ) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  tspft_ram #(
    .WIDTH (PID_LO_W),
    .DEPTH (SMALL_ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (free_idx),
    .wdata (pid_r[PID_LO_W-1:0]),
    .re    (sl_re),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  // lowest-index free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SMALL_ENTRIES - 1; k >= 0; k--) begin
      if (!sl_vld_r[k]) begin
        free_found = 1'b1;
        free_idx   = SLOT_AW'(k);
      end
    end
  end

  // word not yet written reads as zero
  assign bm_old   = bm_vld_r[pid_r[PID_LO_W-1:BIT_SEL_W]] ? bm_rdata : '0;
  assign bm_mask  = WORD_W'(1) << pid_r[BIT_SEL_W-1:0];
  assign bm_wdata = (op_r == OP_SET) ? (bm_old | bm_mask) : (bm_old & ~bm_mask);
  assign bm_waddr = pid_r[PID_LO_W-1:BIT_SEL_W];
  assign bm_raddr = in_pid[PID_LO_W-1:BIT_SEL_W];
  assign sl_raddr = scan_idx_r;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    bypass_nxt     = bypass_r;
    bm_vld_nxt     = bm_vld_r;
    sl_vld_nxt     = sl_vld_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    bm_we          = 1'b0;
    bm_re          = 1'b0;
    sl_we          = 1'b0;
    sl_re          = 1'b0;

    if (cfg_valid) begin
      kind_nxt = cfg_filter_kind;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_operation;
          pid_nxt = in_pid;
          if (kind_r == KIND_FULL) begin
            bm_re     = 1'b1;
            state_nxt = S_BM_WR;
          end else if (in_operation == OP_SET) begin
            state_nxt = S_SM_SET;
          end else begin
            scan_idx_nxt = '0;
            cmp_vld_nxt  = 1'b0;
            state_nxt    = S_SM_SCAN;
          end
        end
      end

      S_BM_WR: begin
        if (pid_r == BYPASS_PID) begin
          bypass_nxt = (op_r == OP_SET);
        end else if (!pid_r[PID_W-1]) begin
          bm_we = 1'b1;
          bm_vld_nxt[pid_r[PID_LO_W-1:BIT_SEL_W]] = 1'b1;
        end
        // PIDs above feed-through are ignored
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_DONE;
        state_nxt      = S_IDLE;
      end

      S_SM_SET: begin
        if (free_found) begin
          sl_we                = 1'b1;
          sl_vld_nxt[free_idx] = 1'b1;
          out_status_nxt       = STATUS_DONE;
        end else begin
          out_status_nxt = STATUS_FULL;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_SM_SCAN: begin
        // read one slot per cycle, compare it the cycle after
        sl_re       = 1'b1;
        cmp_idx_nxt = scan_idx_r;
        cmp_vld_nxt = 1'b1;
        if (scan_idx_r != SLOT_LAST) begin
          scan_idx_nxt = scan_idx_r + SLOT_AW'(1);
        end
        if (cmp_vld_r) begin
          if (sl_vld_r[cmp_idx_r] && (sl_rdata == pid_r[PID_LO_W-1:0])) begin
            sl_vld_nxt[cmp_idx_r] = 1'b0;
            out_valid_nxt         = 1'b1;
            out_status_nxt        = STATUS_DONE;
            cmp_vld_nxt           = 1'b0;
            state_nxt             = S_IDLE;
          end else if (cmp_idx_r == SLOT_LAST) begin
            // no match: nothing changes
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_DONE;
            cmp_vld_nxt    = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_bypass_nxt = bypass_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_FULL;
      bypass_r    <= 1'b0;
      bm_vld_r    <= '0;
      sl_vld_r    <= '0;
      scan_idx_r  <= '0;
      cmp_idx_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      bypass_r    <= bypass_nxt;
      bm_vld_r    <= bm_vld_nxt;
      sl_vld_r    <= sl_vld_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pid_r        <= pid_nxt;
    out_status_r <= out_status_nxt;
    out_bypass_r <= out_bypass_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bypass_on = out_bypass_r;

endmodule
